// ----- rtl/core/ccu_pkg.sv -----
// ----------------------------------------------------------------------------
// ccu_pkg
// Types, codes and constants shared by the condition code unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccu_pkg;

    typedef enum logic [2:0] {
        OP_MOVE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_AND  = 3'd3,
        OP_OR   = 3'd4,
        OP_XOR  = 3'd5,
        OP_BCC  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } t_size;

    typedef enum logic [3:0] {
        CC_T  = 4'd0,
        CC_SR = 4'd1,
        CC_HI = 4'd2,
        CC_LS = 4'd3,
        CC_CC = 4'd4,
        CC_CS = 4'd5,
        CC_NE = 4'd6,
        CC_EQ = 4'd7,
        CC_VC = 4'd8,
        CC_VS = 4'd9,
        CC_PL = 4'd10,
        CC_MI = 4'd11,
        CC_GE = 4'd12,
        CC_LT = 4'd13,
        CC_GT = 4'd14,
        CC_LE = 4'd15
    } t_cond;

    localparam logic [31:0] UPPER_BYTE = 32'hFFFF_FF00;
    localparam logic [31:0] UPPER_WORD = 32'hFFFF_0000;
    localparam logic [31:0] SIGN_LONG  = 32'h8000_0000;
    localparam logic [31:0] SIGN_WORD  = 32'h0000_8000;
    localparam logic [31:0] SIGN_BYTE  = 32'h0000_0080;
    localparam logic [31:0] PC_ADJUST  = 32'd2;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [2:0]         operation;
        logic [1:0]         size_code;
        logic [31:0]        source_value;
        logic [31:0]        dest_value;
        logic [3:0]         condition;
        logic signed [15:0] displacement;
        logic [31:0]        program_counter;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic        flag_negative;
        logic        flag_zero;
        logic        flag_overflow;
        logic        flag_carry;
        logic        branch_taken;
        logic [31:0] next_pc;
    } t_out_item;

    typedef struct packed {
        logic [31:0] result;
        t_flags      flags;
        logic        flags_we;
    } t_alu_res;

    typedef struct packed {
        logic        taken;
        logic [31:0] npc;
    } t_br_res;

endpackage

`default_nettype wire

// ----- rtl/core/ccu_if.sv -----
// ----------------------------------------------------------------------------
// ccu_in_if / ccu_out_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccu_in_if;
    logic              valid;
    logic              ready;
    ccu_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccu_out_if;
    logic               valid;
    logic               ready;
    ccu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ccu_alu.sv -----
// ----------------------------------------------------------------------------
// ccu_alu
// Sized move/add/sub/logic datapath with N, Z, V, C generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ccu_alu (
    input  wire ccu_pkg::t_in_item i_item,
    output ccu_pkg::t_alu_res      o_res
);
    import ccu_pkg::*;

    logic [31:0] w_mask;
    logic [31:0] w_sign;
    logic [31:0] w_s;
    logic [31:0] w_d;
    logic [32:0] w_sum;
    logic [32:0] w_diff;
    logic [31:0] w_r;
    logic        w_carry_add;

    always_comb begin
        case (t_size'(i_item.size_code))
            SZ_BYTE: begin
                w_mask = ~UPPER_BYTE;
                w_sign = SIGN_BYTE;
            end
            SZ_WORD: begin
                w_mask = ~UPPER_WORD;
                w_sign = SIGN_WORD;
            end
            default: begin
                w_mask = '1;
                w_sign = SIGN_LONG;
            end
        endcase
    end

    assign w_s    = i_item.source_value & w_mask;
    assign w_d    = i_item.dest_value & w_mask;
    assign w_sum  = {1'b0, w_d} + {1'b0, w_s};
    assign w_diff = {1'b0, w_d} - {1'b0, w_s};

    always_comb begin
        case (t_size'(i_item.size_code))
            SZ_BYTE: w_carry_add = w_sum[8];
            SZ_WORD: w_carry_add = w_sum[16];
            default: w_carry_add = w_sum[32];
        endcase
    end

    always_comb begin
        o_res.flags_we = 1'b1;
        o_res.flags.v  = 1'b0;
        o_res.flags.c  = 1'b0;
        case (t_op'(i_item.operation))
            OP_MOVE: w_r = w_s;
            OP_AND:  w_r = w_s & w_d;
            OP_OR:   w_r = w_s | w_d;
            OP_XOR:  w_r = w_s ^ w_d;
            OP_ADD: begin
                w_r           = w_sum[31:0] & w_mask;
                o_res.flags.c = w_carry_add;
                o_res.flags.v = |((w_s ^ w_r) & (w_d ^ w_r) & w_sign);
            end
            OP_SUB: begin
                w_r           = w_diff[31:0] & w_mask;
                o_res.flags.c = w_diff[32];
                o_res.flags.v = |((w_s ^ w_d) & (w_d ^ w_r) & w_sign);
            end
            default: begin
                w_r            = w_d;
                o_res.flags_we = 1'b0;
            end
        endcase
        o_res.flags.n = |(w_r & w_sign);
        o_res.flags.z = (w_r == 32'd0);
        if (o_res.flags_we) begin
            o_res.result = (i_item.dest_value & ~w_mask) | w_r;
        end else begin
            o_res.result = i_item.dest_value;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ccu_branch.sv -----
// ----------------------------------------------------------------------------
// ccu_branch
// Condition test against the stored flags and branch target adder.
// ----------------------------------------------------------------------------
`default_nettype none

module ccu_branch (
    input  wire ccu_pkg::t_in_item i_item,
    input  wire ccu_pkg::t_flags   i_flags,
    output ccu_pkg::t_br_res       o_res
);
    import ccu_pkg::*;

    logic w_hold;
    logic n, z, v, c;

    assign n = i_flags.n;
    assign z = i_flags.z;
    assign v = i_flags.v;
    assign c = i_flags.c;

    always_comb begin
        case (t_cond'(i_item.condition))
            CC_T:    w_hold = 1'b1;
            CC_SR:   w_hold = 1'b1;
            CC_HI:   w_hold = !c && !z;
            CC_LS:   w_hold = c || z;
            CC_CC:   w_hold = !c;
            CC_CS:   w_hold = c;
            CC_NE:   w_hold = !z;
            CC_EQ:   w_hold = z;
            CC_VC:   w_hold = !v;
            CC_VS:   w_hold = v;
            CC_PL:   w_hold = !n;
            CC_MI:   w_hold = n;
            CC_GE:   w_hold = (n == v);
            CC_LT:   w_hold = (n != v);
            CC_GT:   w_hold = !z && (n == v);
            default: w_hold = z || (n != v);
        endcase
    end

    always_comb begin
        o_res.taken = (t_op'(i_item.operation) == OP_BCC) && w_hold;
        if (o_res.taken) begin
            o_res.npc = i_item.program_counter
                      + {{16{i_item.displacement[15]}}, i_item.displacement}
                      - PC_ADJUST;
        end else begin
            o_res.npc = i_item.program_counter;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cisc_alu_condition_code_unit.sv -----
// ----------------------------------------------------------------------------
// cisc_alu_condition_code_unit
// Integer execute stage with N/Z/V/C condition codes and conditional branch.
// ----------------------------------------------------------------------------
// One instruction beat is accepted per cycle while the input register can
// take it; acceptance stops when both registers are full and the sink holds
// ready low. A beat is held in the input register for a pass through the
// sized ALU and branch test, then moves into the result register, where its
// result beat is offered. The flag register is written as a beat moves into
// the result register, so the next beat already sees the flags left by the
// one before it. The result register stalls in place while the sink holds
// ready low; the input register keeps taking beats until both are full.
`default_nettype none

module cisc_alu_condition_code_unit (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ccu_in_if.sink    i_in,
    ccu_out_if.source o_out
);
    import ccu_pkg::*;

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_flags    r_flags;

    t_alu_res  w_alu;
    t_br_res   w_br;
    t_flags    n_flags;
    logic      w_adv;

    ccu_alu u_alu (
        .i_item (r_in),
        .o_res  (w_alu)
    );

    ccu_branch u_branch (
        .i_item  (r_in),
        .i_flags (r_flags),
        .o_res   (w_br)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign n_flags    = w_alu.flags_we ? w_alu.flags : r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out.result_value  <= w_alu.result;
            r_out.flag_negative <= n_flags.n;
            r_out.flag_zero     <= n_flags.z;
            r_out.flag_overflow <= n_flags.v;
            r_out.flag_carry    <= n_flags.c;
            r_out.branch_taken  <= w_br.taken;
            r_out.next_pc       <= w_br.npc;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // a waiting result always carries the current flag register
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flag_negative == r_flags.n)
                     && (r_out.flag_zero == r_flags.z)
                     && (r_out.flag_overflow == r_flags.v)
                     && (r_out.flag_carry == r_flags.c))
        else $error("result flags differ from flag register");

    // a beat in the input register survives a stalled output
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |=> r_in_valid && $stable(r_in))
        else $error("pending beat lost under stall");

    // flags only move when a beat advances
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_flags))
        else $error("flags changed without an advancing beat");

endmodule

`default_nettype wire
